@@ sv/bbl_pkg.sv @@
package bbl_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int CFG_W_W    = 9;
  localparam int HEIGHT_W   = 16;
  localparam int ROW_W      = HEIGHT_W + 1;
  localparam int EW_W       = (COL_W + 1 > CFG_W_W) ? COL_W + 1 : CFG_W_W;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int PIX_W      = 8;

  localparam int WIDTH_RESET  = 256;
  localparam int HEIGHT_RESET = 256;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam int STEPQ_DEPTH = 2;
  localparam int STEPQ_PTR_W = $clog2(STEPQ_DEPTH);
  localparam int OQ_DEPTH    = 4;
  localparam int OQ_PTR_W    = $clog2(OQ_DEPTH);

  localparam int SUM_W    = 12;
  localparam int CNT_W    = 4;
  localparam int RECIP_W  = 17;
  localparam int RECIP_SH = 16;
  localparam int PROD_W   = SUM_W + RECIP_W;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             is_pix;
    logic [COL_W-1:0] col;
    logic             due;
    logic             at_edge;
    logic             top_ok;
    logic             bot_ok;
    logic             left_ok;
    logic             right_ok;
    logic             fend;
  } step_t;

  typedef struct packed {
    logic [PIX_W-1:0] blurred;
    logic             fend;
  } res_t;

  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] r;
    unique case (cnt)
      4'd1:    r = RECIP_W'(65536);
      4'd2:    r = RECIP_W'(32768);
      4'd3:    r = RECIP_W'(21846);
      4'd4:    r = RECIP_W'(16384);
      4'd6:    r = RECIP_W'(10923);
      4'd9:    r = RECIP_W'(7282);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/bbl_ram.sv @@
module bbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ sv/bbl_step_q.sv @@
module bbl_step_q (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bbl_pkg::step_t  din,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output bbl_pkg::step_t  dout
);
  import bbl_pkg::*;

  step_t                  mem_r [STEPQ_DEPTH];
  logic [STEPQ_PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [STEPQ_PTR_W:0]   cnt_r, cnt_nxt;
  logic                   do_push, do_pop;

  assign full    = (cnt_r == (STEPQ_PTR_W+1)'(STEPQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = do_push ? wp_r + STEPQ_PTR_W'(1) : wp_r;
    rp_nxt  = do_pop ? rp_r + STEPQ_PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (STEPQ_PTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (STEPQ_PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

@@ sv/bbl_front.sv @@
module bbl_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_op,
  input  logic [bbl_pkg::PIX_W-1:0]      in_pixel,
  input  logic                           cfg_we,
  input  logic [bbl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           q_full,
  output logic                           q_push,
  output bbl_pkg::step_t                 q_data
);
  import bbl_pkg::*;

  typedef enum logic {ST_ITEM, ST_FLUSH2} state_t;

  state_t              state_r, state_nxt;
  logic [CFG_W_W-1:0]  width_r, width_nxt;
  logic [HEIGHT_W-1:0] height_r, height_nxt;
  logic [ROW_W-1:0]    irow_r, irow_nxt;
  logic [COL_W-1:0]    icol_r, icol_nxt;
  logic [HEIGHT_W-1:0] orow_r, orow_nxt;
  logic [COL_W-1:0]    ocol_r, ocol_nxt;

  logic [EW_W-1:0]     weff, icol_inc, ocol_inc;
  logic [HEIGHT_W-1:0] heff;
  logic [ROW_W-1:0]    orow_inc;
  logic                complete, due, fend, accept, step_go, item_pix;

  always_comb begin
    if (width_r == '0) begin
      weff = EW_W'(1);
    end else if (EW_W'(width_r) > EW_W'(MAX_WIDTH)) begin
      weff = EW_W'(MAX_WIDTH);
    end else begin
      weff = EW_W'(width_r);
    end
    heff = (height_r == '0) ? HEIGHT_W'(1) : height_r;
  end

  assign icol_inc = EW_W'(icol_r) + EW_W'(1);
  assign ocol_inc = EW_W'(ocol_r) + EW_W'(1);
  assign orow_inc = ROW_W'(orow_r) + ROW_W'(1);
  assign complete = (irow_r >= ROW_W'(heff));
  assign due      = (irow_r >= ROW_W'(2)) || (irow_r == ROW_W'(1) && icol_r != '0);
  assign fend     = due && (orow_inc >= ROW_W'(heff)) && (ocol_inc >= weff);

  assign in_full  = (state_r == ST_FLUSH2) || q_full;
  assign accept   = in_push && !in_full;
  assign item_pix = (state_r == ST_ITEM) && (in_op == OP_PIXEL);

  always_comb begin
    unique case (state_r)
      ST_ITEM:   step_go = accept && ((in_op == OP_PIXEL) ? !complete : complete);
      ST_FLUSH2: step_go = !q_full;
      default:   step_go = 1'b0;
    endcase
  end

  always_comb begin
    q_push          = step_go;
    q_data.pix      = item_pix ? in_pixel : '0;
    q_data.is_pix   = item_pix;
    q_data.col      = icol_r;
    q_data.due      = due;
    q_data.at_edge  = (ocol_inc == weff);
    q_data.top_ok   = (orow_r != '0);
    q_data.bot_ok   = (orow_inc < ROW_W'(heff));
    q_data.left_ok  = (ocol_r != '0);
    q_data.right_ok = (ocol_inc < weff);
    q_data.fend     = fend;
  end

  always_comb begin
    state_nxt  = state_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    irow_nxt   = irow_r;
    icol_nxt   = icol_r;
    orow_nxt   = orow_r;
    ocol_nxt   = ocol_r;
    if (step_go) begin
      if (icol_inc >= weff) begin
        icol_nxt = '0;
        irow_nxt = irow_r + ROW_W'(1);
      end else begin
        icol_nxt = icol_inc[COL_W-1:0];
      end
      if (due) begin
        if (fend) begin
          irow_nxt = '0;
          icol_nxt = '0;
          orow_nxt = '0;
          ocol_nxt = '0;
        end else if (ocol_inc >= weff) begin
          ocol_nxt = '0;
          orow_nxt = orow_r + HEIGHT_W'(1);
        end else begin
          ocol_nxt = ocol_inc[COL_W-1:0];
        end
      end
      if (state_r == ST_FLUSH2) begin
        state_nxt = ST_ITEM;
      end else if (in_op == OP_FLUSH && !due) begin
        state_nxt = ST_FLUSH2;
      end
    end
    if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width_nxt  = cfg_data[CFG_W_W-1:0];
        REG_HEIGHT: height_nxt = cfg_data[HEIGHT_W-1:0];
        default:    width_nxt  = width_r;
      endcase
      irow_nxt = '0;
      icol_nxt = '0;
      orow_nxt = '0;
      ocol_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_ITEM;
      width_r  <= CFG_W_W'(WIDTH_RESET);
      height_r <= HEIGHT_W'(HEIGHT_RESET);
      irow_r   <= '0;
      icol_r   <= '0;
      orow_r   <= '0;
      ocol_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      irow_r   <= irow_nxt;
      icol_r   <= icol_nxt;
      orow_r   <= orow_nxt;
      ocol_r   <= ocol_nxt;
    end
  end

endmodule

@@ sv/bbl_back.sv @@
module bbl_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  bbl_pkg::step_t            q_data,
  output logic                      q_pop,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [bbl_pkg::PIX_W-1:0] out_blurred,
  output logic                      out_frame_end
);
  import bbl_pkg::*;

  step_t              s1_r;
  logic               s1_v_r;
  logic               byp_v_r;
  logic [PIX_W-1:0]   byp_old_r, byp_new_r;
  logic [PIX_W-1:0]   older_q, newer_q, older_eff, newer_eff;
  logic [PIX_W-1:0]   win_r [3][3];
  logic [PIX_W-1:0]   newcol [3];
  logic [PIX_W-1:0]   tap [3][3];
  logic               row_ok [3];
  logic               col_ok [3];
  logic [SUM_W-1:0]   sum;
  logic [CNT_W-1:0]   cnt;

  logic               s2_v_r;
  logic [SUM_W-1:0]   s2_sum_r;
  logic [CNT_W-1:0]   s2_cnt_r;
  logic               s2_fend_r;
  logic [PROD_W-1:0]  prod;

  res_t               oq_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wp_r, oq_rp_r;
  logic [OQ_PTR_W:0]  oq_cnt_r, oq_cnt_nxt;
  logic [OQ_PTR_W+1:0] committed;
  logic               oq_rd;
  res_t               oq_head;

  assign committed = (OQ_PTR_W+2)'(oq_cnt_r) + (OQ_PTR_W+2)'(s1_v_r) + (OQ_PTR_W+2)'(s2_v_r);
  assign q_pop     = !q_empty && (committed < (OQ_PTR_W+2)'(OQ_DEPTH));

  bbl_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk   (clk),
    .we    (s1_v_r && s1_r.is_pix),
    .waddr (s1_r.col),
    .wdata (newer_eff),
    .raddr (q_data.col),
    .rdata (older_q)
  );

  bbl_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
    .clk   (clk),
    .we    (s1_v_r && s1_r.is_pix),
    .waddr (s1_r.col),
    .wdata (s1_r.pix),
    .raddr (q_data.col),
    .rdata (newer_q)
  );

  assign older_eff = byp_v_r ? byp_old_r : older_q;
  assign newer_eff = byp_v_r ? byp_new_r : newer_q;

  always_comb begin
    newcol[0] = older_eff;
    newcol[1] = newer_eff;
    newcol[2] = s1_r.pix;
    row_ok[0] = s1_r.top_ok;
    row_ok[1] = 1'b1;
    row_ok[2] = s1_r.bot_ok;
    col_ok[0] = s1_r.left_ok;
    col_ok[1] = 1'b1;
    col_ok[2] = s1_r.right_ok;
    for (int r = 0; r < 3; r++) begin
      if (s1_r.at_edge) begin
        tap[r][0] = win_r[r][1];
        tap[r][1] = win_r[r][2];
        tap[r][2] = win_r[r][2];
      end else begin
        tap[r][0] = win_r[r][1];
        tap[r][1] = win_r[r][2];
        tap[r][2] = newcol[r];
      end
    end
    sum = '0;
    cnt = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_ok[r] && col_ok[c]) begin
          sum = sum + SUM_W'(tap[r][c]);
          cnt = cnt + CNT_W'(1);
        end
      end
    end
  end

  assign prod = PROD_W'(s2_sum_r) * PROD_W'(recip(s2_cnt_r));

  assign oq_head       = oq_r[oq_rp_r];
  assign out_empty     = (oq_cnt_r == '0);
  assign out_blurred   = oq_head.blurred;
  assign out_frame_end = oq_head.fend;
  assign oq_rd         = out_pop && !out_empty;

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (s2_v_r && !oq_rd) begin
      oq_cnt_nxt = oq_cnt_r + (OQ_PTR_W+1)'(1);
    end else if (oq_rd && !s2_v_r) begin
      oq_cnt_nxt = oq_cnt_r - (OQ_PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      byp_v_r  <= 1'b0;
      s2_v_r   <= 1'b0;
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else begin
      s1_v_r   <= q_pop;
      byp_v_r  <= q_pop && s1_v_r && s1_r.is_pix && (s1_r.col == q_data.col);
      s2_v_r   <= s1_v_r && s1_r.due;
      oq_cnt_r <= oq_cnt_nxt;
      if (s2_v_r) begin
        oq_wp_r <= oq_wp_r + OQ_PTR_W'(1);
      end
      if (oq_rd) begin
        oq_rp_r <= oq_rp_r + OQ_PTR_W'(1);
      end
      if (s1_v_r) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
          win_r[r][2] <= newcol[r];
        end
      end
    end
    if (q_pop) begin
      s1_r <= q_data;
    end
    byp_old_r <= newer_eff;
    byp_new_r <= s1_r.pix;
    s2_sum_r  <= sum;
    s2_cnt_r  <= cnt;
    s2_fend_r <= s1_r.fend;
    if (s2_v_r) begin
      oq_r[oq_wp_r] <= '{blurred: prod[RECIP_SH+PIX_W-1:RECIP_SH], fend: s2_fend_r};
    end
  end

endmodule

@@ sv/box_blur_3x3_stream.sv @@
// Path: the item that completes a result's window passes the step queue, stage s1, stage s2
// and the output queue before the result is visible on the out_ ports; that item lags the
// pixel by one row plus one pixel.
// Throughput: one item per cycle while in_full is low; in_full is high while the step queue is full
// and while a flush that must push two virtual pixels issues its second window step.
// Reset (rst_n low, synchronous): queues empty, window zero, position counters zero,
// image_width and image_height 256; line buffer contents are left as they are.
module box_blur_3x3_stream (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_op,
  input  logic [bbl_pkg::PIX_W-1:0]      in_pixel,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [bbl_pkg::PIX_W-1:0]      out_blurred,
  output logic                           out_frame_end,
  input  logic                           cfg_we,
  input  logic [bbl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bbl_pkg::*;

  logic  sq_push, sq_full, sq_pop, sq_empty;
  step_t sq_din, sq_dout;

  bbl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_op     (in_op),
    .in_pixel  (in_pixel),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (sq_full),
    .q_push    (sq_push),
    .q_data    (sq_din)
  );

  bbl_step_q u_step_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (sq_push),
    .din   (sq_din),
    .full  (sq_full),
    .pop   (sq_pop),
    .empty (sq_empty),
    .dout  (sq_dout)
  );

  bbl_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (sq_empty),
    .q_data        (sq_dout),
    .q_pop         (sq_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_blurred   (out_blurred),
    .out_frame_end (out_frame_end)
  );

endmodule
